FILE: rtl/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the DDA line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dda_pkg;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam int Q_ADDR_BITS = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/dda_fifo.sv
// ----------------------------------------------------------------------------
// dda_fifo
// Short command queue between the front classifier and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_fifo #(
  parameter int WIDTH = 53
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic                 pop,
  output logic      [WIDTH-1:0]     rd_data,
  output dda_pkg::fifo_status_t     status
);

  localparam int A     = dda_pkg::Q_ADDR_BITS;
  localparam int DEPTH = 1 << A;

  logic [WIDTH-1:0] entries [DEPTH];
  logic [A-1:0]     wr_ptr;
  logic [A-1:0]     rd_ptr;
  logic [A:0]       count;

  logic do_push;
  logic do_pop;

  assign status.full  = (count == (A+1)'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_data      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dda_front.sv
// ----------------------------------------------------------------------------
// dda_front
// Accepts items, sorts start from step, and precomputes the deltas and
// step count of a new line before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_front #(
  parameter int COORD_BITS = 10
) (
  input  wire logic                    cmd_valid,
  output logic                         cmd_stall,
  input  wire logic                    func,
  input  wire logic [COORD_BITS-1:0]   x_start,
  input  wire logic [COORD_BITS-1:0]   y_start,
  input  wire logic [COORD_BITS-1:0]   x_end,
  input  wire logic [COORD_BITS-1:0]   y_end,
  input  wire dda_pkg::fifo_status_t   status,
  output logic                         push,
  output logic [3+5*COORD_BITS-1:0]    entry
);

  localparam int C = COORD_BITS;

  logic         is_start;
  logic         neg_x;
  logic         neg_y;
  logic [C-1:0] adx;
  logic [C-1:0] ady;
  logic [C-1:0] steps;

  always_comb begin
    is_start = (func == dda_pkg::FUNC_START);
    neg_x    = x_end < x_start;
    neg_y    = y_end < y_start;
    adx      = neg_x ? (x_start - x_end) : (x_end - x_start);
    ady      = neg_y ? (y_start - y_end) : (y_end - y_start);
    steps    = (adx > ady) ? adx : ady;
  end

  assign cmd_stall = status.full;
  assign push      = cmd_valid && !status.full;
  assign entry     = {is_start, neg_x, neg_y, x_start, y_start, adx, ady, steps};

endmodule

`default_nettype wire

FILE: rtl/dda_back.sv
// ----------------------------------------------------------------------------
// dda_back
// Runs queued commands: line setup through a radix-2 divider pair, pixel
// steps through the position accumulators into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_back #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [3+5*COORD_BITS-1:0] entry,
  input  wire dda_pkg::fifo_status_t   status,
  output logic                         pop,
  output logic                         pix_valid,
  input  wire logic                    pix_stall,
  output logic [COORD_BITS-1:0]        pixel_x,
  output logic [COORD_BITS-1:0]        pixel_y,
  output logic                         last_pixel
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PB = C + F;
  localparam int SB = PB + 1;
  localparam int CW = $clog2(F + 1);

  // queue head fields
  logic         e_start;
  logic         e_neg_x;
  logic         e_neg_y;
  logic [C-1:0] e_xs;
  logic [C-1:0] e_ys;
  logic [C-1:0] e_adx;
  logic [C-1:0] e_ady;
  logic [C-1:0] e_steps;

  assign {e_start, e_neg_x, e_neg_y, e_xs, e_ys, e_adx, e_ady, e_steps} = entry;

  dda_pkg::back_state_t state;
  dda_pkg::back_state_t state_next;

  logic [PB-1:0] pos_x;
  logic [PB-1:0] pos_y;
  logic [SB-1:0] step_x;
  logic [SB-1:0] step_y;
  logic [C:0]    pixels_left;

  logic [CW-1:0] div_cnt;
  logic [C-1:0]  div_steps;
  logic [C-1:0]  rem_x;
  logic [C-1:0]  rem_y;
  logic [F:0]    quo_x;
  logic [F:0]    quo_y;
  logic          neg_x;
  logic          neg_y;
  logic [C-1:0]  xs;
  logic [C-1:0]  ys;

  logic out_free;
  logic emit;
  logic div_start;
  logic div_load;

  // divider iteration
  logic          nz_steps;
  logic [C:0]    sh_x;
  logic [C:0]    sh_y;
  logic          bit_x;
  logic          bit_y;
  logic [C:0]    rem_x_next;
  logic [C:0]    rem_y_next;
  logic [F:0]    quo_x_next;
  logic [F:0]    quo_y_next;
  logic [SB-1:0] mag_x;
  logic [SB-1:0] mag_y;

  // first quotient bit
  logic          init_x;
  logic          init_y;

  assign out_free = !pix_valid || !pix_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      dda_pkg::ST_RUN: begin
        if (div_start) begin
          state_next = dda_pkg::ST_DIV;
        end
      end
      dda_pkg::ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = dda_pkg::ST_RUN;
        end
      end
      default: state_next = dda_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    div_start = 1'b0;
    div_load  = 1'b0;
    unique case (state)
      dda_pkg::ST_RUN: begin
        if (!status.empty) begin
          if (e_start) begin
            pop       = 1'b1;
            div_start = 1'b1;
          end else if (pixels_left == '0) begin
            pop = 1'b1;
          end else if (out_free) begin
            pop  = 1'b1;
            emit = 1'b1;
          end
        end
      end
      dda_pkg::ST_DIV: begin
        div_load = (div_cnt == '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    nz_steps   = (div_steps != '0);
    sh_x       = {rem_x, 1'b0};
    sh_y       = {rem_y, 1'b0};
    bit_x      = nz_steps && (sh_x >= {1'b0, div_steps});
    bit_y      = nz_steps && (sh_y >= {1'b0, div_steps});
    rem_x_next = bit_x ? (sh_x - {1'b0, div_steps}) : sh_x;
    rem_y_next = bit_y ? (sh_y - {1'b0, div_steps}) : sh_y;
    quo_x_next = {quo_x[F-1:0], bit_x};
    quo_y_next = {quo_y[F-1:0], bit_y};
    mag_x      = SB'(quo_x_next);
    mag_y      = SB'(quo_y_next);
    init_x     = (e_steps != '0) && (e_adx >= e_steps);
    init_y     = (e_steps != '0) && (e_ady >= e_steps);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dda_pkg::ST_RUN;
      pos_x       <= '0;
      pos_y       <= '0;
      step_x      <= '0;
      step_y      <= '0;
      pixels_left <= '0;
      div_cnt     <= '0;
      pix_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free) begin
        pix_valid <= emit;
      end
      if (div_start) begin
        div_cnt <= CW'(F - 1);
      end else if (state == dda_pkg::ST_DIV && div_cnt != '0) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (div_load) begin
        step_x      <= neg_x ? (SB'(0) - mag_x) : mag_x;
        step_y      <= neg_y ? (SB'(0) - mag_y) : mag_y;
        pos_x       <= {xs, F'(0)};
        pos_y       <= {ys, F'(0)};
        pixels_left <= {1'b0, div_steps};
      end else if (emit) begin
        pos_x       <= pos_x + step_x[PB-1:0];
        pos_y       <= pos_y + step_y[PB-1:0];
        pixels_left <= pixels_left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_steps <= e_steps;
      neg_x     <= e_neg_x;
      neg_y     <= e_neg_y;
      xs        <= e_xs;
      ys        <= e_ys;
      rem_x     <= init_x ? (e_adx - e_steps) : e_adx;
      rem_y     <= init_y ? (e_ady - e_steps) : e_ady;
      quo_x     <= {F'(0), init_x};
      quo_y     <= {F'(0), init_y};
    end else if (state == dda_pkg::ST_DIV) begin
      rem_x <= rem_x_next[C-1:0];
      rem_y <= rem_y_next[C-1:0];
      quo_x <= quo_x_next;
      quo_y <= quo_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x    <= pos_x[PB-1:F];
      pixel_y    <= pos_y[PB-1:F];
      last_pixel <= (pixels_left == (C+1)'(1));
    end
  end

  a_no_emit_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == dda_pkg::ST_DIV) |-> (!emit && !pop))
    else $error("pixel issued during line setup");

  a_emit_needs_line: assert property (@(posedge clk) disable iff (rst)
    emit |-> (pixels_left != '0))
    else $error("pixel issued with no active line");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    div_load |=> (state == dda_pkg::ST_RUN && pixels_left == {1'b0, $past(div_steps)}))
    else $error("line setup loaded a wrong pixel count");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (emit && pixels_left == (C+1)'(1)) |=> (pixels_left == '0))
    else $error("line did not end after its last pixel");

endmodule

`default_nettype wire

FILE: rtl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer with fixed-point increments.
//
//   channel  handshake             payload
//   cmd      cmd_valid/cmd_stall   func, x_start, y_start, x_end, y_end
//   pix      pix_valid/pix_stall   pixel_x, pixel_y, last_pixel
//
// A step item issues one pixel per cycle while pix is not stalled and no line
// setup is running; with no active line it is dropped. A start item holds the
// back end while two radix-2 dividers run side by side (one quotient bit per
// cycle). A four-entry queue separates intake from execution, so cmd stalls
// only when that queue is full.
// rst is synchronous, active high, and clears the line state to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_stall,
  input  wire logic                  func,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_end,
  input  wire logic [COORD_BITS-1:0] y_end,
  output logic                       pix_valid,
  input  wire logic                  pix_stall,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic                       last_pixel
);

  localparam int EW = 3 + 5 * COORD_BITS;

  dda_pkg::fifo_status_t status;
  logic                  push;
  logic                  pop;
  logic [EW-1:0]         wr_entry;
  logic [EW-1:0]         rd_entry;

  dda_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .func      (func),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .status    (status),
    .push      (push),
    .entry     (wr_entry)
  );

  dda_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .status  (status)
  );

  dda_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .entry      (rd_entry),
    .status     (status),
    .pop        (pop),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
  );

endmodule

`default_nettype wire
